@@ design/clip_triangles_by_plane_macros.svh @@
`ifndef CLIP_TRIANGLES_BY_PLANE_MACROS_SVH
`define CLIP_TRIANGLES_BY_PLANE_MACROS_SVH

// Concurrent check on the rising clock, quiet while reset is high.
`define CTP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check on the rising clock, active during reset too.
`define CTP_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/ctp_pkg.sv @@
`default_nettype none
package ctp_pkg;

   localparam int INDEX_BITS_DEFAULT = 16;
   localparam int IDX_W              = 16;
   localparam int POS_W              = 32;
   localparam int FRAC_BITS          = 16;
   localparam int PROD_W             = 2 * POS_W;
   localparam int TERM_W             = PROD_W - FRAC_BITS;
   localparam int DIST_W             = TERM_W + 4;
   localparam int REM_W              = DIST_W + 2;
   localparam int QUO_W              = 32;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 32;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic KIND_VERTEX   = 1'b0;
   localparam logic KIND_TRIANGLE = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_NORMAL_X     = 3'd0,
      CSR_NORMAL_Y     = 3'd1,
      CSR_NORMAL_Z     = 3'd2,
      CSR_PLANE_OFFSET = 3'd3,
      CSR_VERTEX_BASE  = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      JOB_PASS    = 2'd0,
      JOB_CUT_ONE = 2'd1,
      JOB_CUT_TWO = 2'd2
   } job_class_type;

   typedef struct packed {
      logic [IDX_W-1:0]        index_a;
      logic [IDX_W-1:0]        index_b;
      logic [IDX_W-1:0]        index_c;
      logic signed [POS_W-1:0] a_x;
      logic signed [POS_W-1:0] a_y;
      logic signed [POS_W-1:0] a_z;
      logic signed [POS_W-1:0] b_x;
      logic signed [POS_W-1:0] b_y;
      logic signed [POS_W-1:0] b_z;
      logic signed [POS_W-1:0] c_x;
      logic signed [POS_W-1:0] c_y;
      logic signed [POS_W-1:0] c_z;
   } ctp_req_type;

   typedef struct packed {
      logic                    kind;
      logic [IDX_W-1:0]        out_index_a;
      logic [IDX_W-1:0]        out_index_b;
      logic [IDX_W-1:0]        out_index_c;
      logic signed [POS_W-1:0] pos_x;
      logic signed [POS_W-1:0] pos_y;
      logic signed [POS_W-1:0] pos_z;
      logic                    last;
      logic                    vertex_overflow;
   } ctp_rsp_type;

   typedef struct packed {
      logic signed [POS_W-1:0] normal_x;
      logic signed [POS_W-1:0] normal_y;
      logic signed [POS_W-1:0] normal_z;
      logic signed [POS_W-1:0] plane_offset;
   } ctp_plane_type;

   typedef struct packed {
      logic [2:0][IDX_W-1:0]        idx;
      logic [2:0][2:0][POS_W-1:0]   pos;
      logic [2:0][DIST_W-1:0]       corner_dist;
      job_class_type                job_class;
      logic [1:0]                   m0;
      logic [1:0]                   m1;
      logic [1:0]                   m2;
   } ctp_job_type;

endpackage
`default_nettype wire

@@ design/ctp_front.sv @@
`default_nettype none
module ctp_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire ctp_pkg::ctp_req_type req_data,
   input  wire ctp_pkg::ctp_plane_type plane,
   output logic                      job_valid,
   input  wire logic                 job_ready,
   output ctp_pkg::ctp_job_type      job_data
);
   import ctp_pkg::*;

   localparam logic [3:0] TERMS = 4'd9;

   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_CALC = 3'b010,
      F_PUSH = 3'b100
   } front_state_type;

   front_state_type              state_ff, state_in;
   logic [2:0][IDX_W-1:0]        idx_ff, idx_in;
   logic [2:0][2:0][POS_W-1:0]   pos_ff, pos_in;
   logic [2:0][DIST_W-1:0]       dist_ff, dist_in;
   logic [3:0]                   step_ff, step_in;
   logic [1:0]                   corner_ff, corner_in;
   logic [1:0]                   axis_ff, axis_in;
   logic signed [PROD_W-1:0]     prod_ff, prod_in;
   logic [1:0]                   prod_corner_ff, prod_corner_in;

   logic signed [POS_W-1:0]      mul_n;
   logic signed [POS_W-1:0]      mul_p;
   logic [DIST_W-1:0]            term;
   logic [DIST_W-1:0]            neg_offset;
   logic [2:0]                   neg;
   logic [2:0]                   zero;
   logic                         drop;
   logic                         pass;
   logic [1:0]                   m0, m1, m2;

   // Pick the normal component of the current axis
   always_comb begin
      unique case (axis_ff)
         2'd0:    mul_n = plane.normal_x;
         2'd1:    mul_n = plane.normal_y;
         default: mul_n = plane.normal_z;
      endcase
      mul_p = $signed(pos_ff[corner_ff][axis_ff]);
   end

   // Floor of the product over 2^16 is its upper bits
   assign term = {{(DIST_W-TERM_W){prod_ff[PROD_W-1]}}, prod_ff[PROD_W-1:FRAC_BITS]};
   assign neg_offset = -{{(DIST_W-POS_W){plane.plane_offset[POS_W-1]}}, plane.plane_offset};

   // Classify the finished distances and rotate the corners
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         neg[k]  = dist_ff[k][DIST_W-1];
         zero[k] = (dist_ff[k] == '0);
      end
      drop = (neg[0] | zero[0]) & (neg[1] | zero[1]) & (neg[2] | zero[2]);
      pass = !neg[0] && !neg[1] && !neg[2];
      m0 = 2'd0; m1 = 2'd1; m2 = 2'd2;
      if (!neg[0]) begin
         if (neg[1] && !neg[2]) begin
            m0 = 2'd2; m1 = 2'd0; m2 = 2'd1;
         end
      end else if (!neg[1]) begin
         m0 = 2'd1; m1 = 2'd2; m2 = 2'd0;
      end else begin
         m0 = 2'd2; m1 = 2'd0; m2 = 2'd1;
      end
   end

   always_comb begin
      job_data.idx         = idx_ff;
      job_data.pos         = pos_ff;
      job_data.corner_dist = dist_ff;
      job_data.m0          = m0;
      job_data.m1          = m1;
      job_data.m2          = m2;
      if (pass) begin
         job_data.job_class = JOB_PASS;
      end else if (neg[m1]) begin
         job_data.job_class = JOB_CUT_ONE;
      end else begin
         job_data.job_class = JOB_CUT_TWO;
      end
   end

   assign req_ready = (state_ff == F_IDLE);
   assign job_valid = (state_ff == F_PUSH) && !drop;

   // Sequence nine products through one multiplier, accumulate each registered product
   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      pos_in         = pos_ff;
      dist_in        = dist_ff;
      step_in        = step_ff;
      corner_in      = corner_ff;
      axis_in        = axis_ff;
      prod_in        = prod_ff;
      prod_corner_in = prod_corner_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               idx_in    = {req_data.index_c, req_data.index_b, req_data.index_a};
               pos_in[0] = {req_data.a_z, req_data.a_y, req_data.a_x};
               pos_in[1] = {req_data.b_z, req_data.b_y, req_data.b_x};
               pos_in[2] = {req_data.c_z, req_data.c_y, req_data.c_x};
               dist_in   = {3{neg_offset}};
               step_in   = '0;
               corner_in = '0;
               axis_in   = '0;
               state_in  = F_CALC;
            end
         end
         F_CALC: begin
            if (step_ff != TERMS) begin
               prod_in        = mul_n * mul_p;
               prod_corner_in = corner_ff;
               if (axis_ff == 2'd2) begin
                  axis_in   = '0;
                  corner_in = corner_ff + 2'd1;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
            if (step_ff != '0) begin
               dist_in[prod_corner_ff] = dist_ff[prod_corner_ff] + term;
            end
            step_in = step_ff + 4'd1;
            if (step_ff == TERMS) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (drop || job_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff         <= idx_in;
      pos_ff         <= pos_in;
      dist_ff        <= dist_in;
      step_ff        <= step_in;
      corner_ff      <= corner_in;
      axis_ff        <= axis_in;
      prod_ff        <= prod_in;
      prod_corner_ff <= prod_corner_in;
   end

endmodule
`default_nettype wire

@@ design/ctp_queue.sv @@
`default_nettype none
module ctp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire ctp_pkg::ctp_job_type in_data,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output ctp_pkg::ctp_job_type      out_data
);
   import ctp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   ctp_job_type        entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]     count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != (PTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers and count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

@@ design/ctp_back.sv @@
`default_nettype none
module ctp_back #(
   parameter int INDEX_BITS = ctp_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      job_valid,
   output logic                           job_ready,
   input  wire ctp_pkg::ctp_job_type      job_data,
   input  wire logic                      base_load,
   input  wire logic [ctp_pkg::IDX_W-1:0] base_value,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output ctp_pkg::ctp_rsp_type           rsp_data
);
   import ctp_pkg::*;

   localparam int NV_W   = ((INDEX_BITS > IDX_W) ? INDEX_BITS : IDX_W) + 1;
   localparam int HALF   = POS_W / 2;
   localparam int MAG_W  = POS_W + 1;
   localparam int HI_W   = MAG_W - HALF;
   localparam int HIP_W  = HI_W + QUO_W;
   localparam int LOP_W  = HALF + QUO_W;
   localparam int SUM_W  = HIP_W + 1;
   localparam logic [NV_W-1:0] VMAX = NV_W'((64'd1 << INDEX_BITS) - 64'd1);
   localparam logic [4:0]      DIV_LAST = 5'(QUO_W - 1);

   typedef enum logic [6:0] {
      B_IDLE   = 7'b0000001,
      B_SETUP  = 7'b0000010,
      B_DIV    = 7'b0000100,
      B_MUL_HI = 7'b0001000,
      B_MUL_LO = 7'b0010000,
      B_SUM    = 7'b0100000,
      B_EMIT   = 7'b1000000
   } back_state_type;

   back_state_type              state_ff, state_in;
   ctp_job_type                 job_ff, job_in;
   logic [NV_W-1:0]             nv_ff, nv_in;
   logic [IDX_W-1:0]            n0_ff, n0_in;
   logic [IDX_W-1:0]            n1_ff, n1_in;
   logic                        ovf_ff, ovf_in;
   logic                        cut_ff, cut_in;
   logic [1:0]                  axis_ff, axis_in;
   logic [4:0]                  div_cnt_ff, div_cnt_in;
   logic [REM_W-1:0]            rem_ff, rem_in;
   logic [REM_W-1:0]            den_ff, den_in;
   logic [QUO_W-1:0]            quo_ff, quo_in;
   logic [HIP_W-1:0]            hi_prod_ff, hi_prod_in;
   logic [LOP_W-1:0]            lo_prod_ff, lo_prod_in;
   logic [1:0][2:0][POS_W-1:0]  npos_ff, npos_in;
   logic [1:0]                  emit_ff, emit_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ctp_rsp_type                 rsp_ff, rsp_in;

   logic [1:0]                  ea, eb;
   logic [REM_W-1:0]            rem_shift;
   logic signed [MAG_W-1:0]     delta;
   logic [MAG_W-1:0]            mag;
   logic [SUM_W-1:0]            frac_sum;
   logic [MAG_W-1:0]            step_len;
   logic [MAG_W-1:0]            pa_ext;
   logic [MAG_W-1:0]            new_pos;
   logic                        ov0, ov1;
   logic [NV_W-1:0]             take0, take1, nv_mid, nv_end;
   logic [2:0][IDX_W-1:0]       tri_idx;
   logic [1:0]                  last_emit;
   logic                        out_free;
   ctp_rsp_type                 rec;

   // Endpoints of the edge under work: toward the back corner
   always_comb begin
      ea = (!cut_ff || job_ff.job_class == JOB_CUT_ONE) ? job_ff.m0 : job_ff.m1;
      eb = (!cut_ff && job_ff.job_class == JOB_CUT_ONE) ? job_ff.m1 : job_ff.m2;
   end

   // Restoring divider step and per-axis interpolation terms
   always_comb begin
      rem_shift = {rem_ff[REM_W-2:0], 1'b0};
      delta     = $signed({job_ff.pos[eb][axis_ff][POS_W-1], job_ff.pos[eb][axis_ff]})
                - $signed({job_ff.pos[ea][axis_ff][POS_W-1], job_ff.pos[ea][axis_ff]});
      mag       = delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
      frac_sum  = SUM_W'(hi_prod_ff) + SUM_W'(lo_prod_ff[LOP_W-1:HALF]);
      step_len  = MAG_W'(frac_sum[SUM_W-1:HALF]);
      pa_ext    = {job_ff.pos[ea][axis_ff][POS_W-1], job_ff.pos[ea][axis_ff]};
      new_pos   = delta[MAG_W-1] ? pa_ext - step_len : pa_ext + step_len;
   end

   // Take two vertex indices from the saturating counter
   always_comb begin
      ov0    = (nv_ff > VMAX);
      take0  = ov0 ? VMAX : nv_ff;
      nv_mid = ov0 ? nv_ff : nv_ff + 1'b1;
      ov1    = (nv_mid > VMAX);
      take1  = ov1 ? VMAX : nv_mid;
      nv_end = ov1 ? nv_mid : nv_mid + 1'b1;
   end

   // Build the result item for the current emit slot
   always_comb begin
      tri_idx = job_ff.idx;
      last_emit = 2'd0;
      unique case (job_ff.job_class)
         JOB_CUT_ONE: begin
            tri_idx[job_ff.m1] = n0_ff;
            tri_idx[job_ff.m2] = n1_ff;
            last_emit = 2'd2;
         end
         JOB_CUT_TWO: begin
            tri_idx[job_ff.m2] = n0_ff;
            last_emit = 2'd3;
         end
         default: last_emit = 2'd0;
      endcase
      rec = '0;
      rec.vertex_overflow = ovf_ff;
      rec.last = (emit_ff == last_emit);
      unique case (emit_ff)
         2'd0: begin
            if (job_ff.job_class == JOB_PASS) begin
               rec.kind        = KIND_TRIANGLE;
               rec.out_index_a = tri_idx[0];
               rec.out_index_b = tri_idx[1];
               rec.out_index_c = tri_idx[2];
            end else begin
               rec.kind        = KIND_VERTEX;
               rec.out_index_a = n0_ff;
               rec.pos_x       = npos_ff[0][0];
               rec.pos_y       = npos_ff[0][1];
               rec.pos_z       = npos_ff[0][2];
            end
         end
         2'd1: begin
            rec.kind        = KIND_VERTEX;
            rec.out_index_a = n1_ff;
            rec.pos_x       = npos_ff[1][0];
            rec.pos_y       = npos_ff[1][1];
            rec.pos_z       = npos_ff[1][2];
         end
         2'd2: begin
            rec.kind        = KIND_TRIANGLE;
            rec.out_index_a = tri_idx[0];
            rec.out_index_b = tri_idx[1];
            rec.out_index_c = tri_idx[2];
         end
         default: begin
            rec.kind        = KIND_TRIANGLE;
            rec.out_index_a = n0_ff;
            rec.out_index_b = job_ff.idx[job_ff.m1];
            rec.out_index_c = n1_ff;
         end
      endcase
   end

   assign job_ready = (state_ff == B_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Sequencer: load job, for a cut divide and interpolate each axis, emit items
   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      nv_in        = nv_ff;
      n0_in        = n0_ff;
      n1_in        = n1_ff;
      ovf_in       = ovf_ff;
      cut_in       = cut_ff;
      axis_in      = axis_ff;
      div_cnt_in   = div_cnt_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      hi_prod_in   = hi_prod_ff;
      lo_prod_in   = lo_prod_ff;
      npos_in      = npos_ff;
      emit_in      = emit_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         B_IDLE: begin
            if (job_valid) begin
               job_in  = job_data;
               emit_in = '0;
               cut_in  = 1'b0;
               if (job_data.job_class == JOB_PASS) begin
                  ovf_in   = 1'b0;
                  state_in = B_EMIT;
               end else begin
                  n0_in    = take0[IDX_W-1:0];
                  n1_in    = take1[IDX_W-1:0];
                  ovf_in   = ov0 | ov1;
                  nv_in    = nv_end;
                  state_in = B_SETUP;
               end
            end
         end
         B_SETUP: begin
            rem_in     = {{(REM_W-DIST_W){1'b0}}, job_ff.corner_dist[ea]};
            den_in     = {{(REM_W-DIST_W){job_ff.corner_dist[ea][DIST_W-1]}},
                          job_ff.corner_dist[ea]}
                       - {{(REM_W-DIST_W){job_ff.corner_dist[eb][DIST_W-1]}},
                          job_ff.corner_dist[eb]};
            quo_in     = '0;
            div_cnt_in = '0;
            state_in   = B_DIV;
         end
         B_DIV: begin
            if (rem_shift >= den_ff) begin
               rem_in = rem_shift - den_ff;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_shift;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
            div_cnt_in = div_cnt_ff + 5'd1;
            if (div_cnt_ff == DIV_LAST) begin
               axis_in  = '0;
               state_in = B_MUL_HI;
            end
         end
         B_MUL_HI: begin
            hi_prod_in = mag[MAG_W-1:HALF] * quo_ff;
            state_in   = B_MUL_LO;
         end
         B_MUL_LO: begin
            lo_prod_in = mag[HALF-1:0] * quo_ff;
            state_in   = B_SUM;
         end
         B_SUM: begin
            npos_in[cut_ff][axis_ff] = new_pos[POS_W-1:0];
            if (axis_ff == 2'd2) begin
               if (cut_ff) begin
                  state_in = B_EMIT;
               end else begin
                  cut_in   = 1'b1;
                  state_in = B_SETUP;
               end
            end else begin
               axis_in  = axis_ff + 2'd1;
               state_in = B_MUL_HI;
            end
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_in       = rec;
               rsp_valid_in = 1'b1;
               emit_in      = emit_ff + 2'd1;
               if (rec.last) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
      // Reload the counter on a base write
      if (base_load) begin
         nv_in = NV_W'(base_value);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         nv_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nv_ff        <= nv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff     <= job_in;
      n0_ff      <= n0_in;
      n1_ff      <= n1_in;
      ovf_ff     <= ovf_in;
      cut_ff     <= cut_in;
      axis_ff    <= axis_in;
      div_cnt_ff <= div_cnt_in;
      rem_ff     <= rem_in;
      den_ff     <= den_in;
      quo_ff     <= quo_in;
      hi_prod_ff <= hi_prod_in;
      lo_prod_ff <= lo_prod_in;
      npos_ff    <= npos_in;
      emit_ff    <= emit_in;
      rsp_ff     <= rsp_in;
   end

endmodule
`default_nettype wire

@@ design/clip_triangles_by_plane.sv @@
// Triangle clipping against one plane.
// Input channel req_*: one triangle item per handshake (three indices and
// three Q16.16 corner positions). Result channel rsp_*: zero to four items
// per triangle, in order, the final one flagged by last.
// Config port csr_*: single-cycle writes of the plane normal, offset and
// vertex base; writing the vertex base reloads the new-vertex counter.
// The front section accepts a triangle and computes the three distances
// with one shared 32x32 multiplier, one triangle at a time.
// A two-entry queue decouples it from the back section, which cuts
// straddling triangles: two 32-step restoring divisions plus three
// steps per axis (high multiply, low multiply, sum), then one result
// per cycle while the receiver is ready. Passing triangles go straight
// to the emit state in the back; dropped ones never reach it.
// Reset (synchronous) empties both sections and the queue, loads the reset
// plane and clears the vertex counter. A stalled receiver holds the result
// register; the back section and then the queue and front fill up and
// deassert req_ready.
`default_nettype none
module clip_triangles_by_plane #(
   parameter int INDEX_BITS = ctp_pkg::INDEX_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire ctp_pkg::ctp_req_type            req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output ctp_pkg::ctp_rsp_type                 rsp_data,
   input  wire logic                            csr_we,
   input  wire logic [ctp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ctp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import ctp_pkg::*;

   ctp_plane_type plane_ff, plane_in;
   logic          job_valid_f, job_ready_f;
   ctp_job_type   job_data_f;
   logic          job_valid_b, job_ready_b;
   ctp_job_type   job_data_b;
   logic          base_load;

   // Decode register writes
   always_comb begin
      plane_in = plane_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_NORMAL_X:     plane_in.normal_x     = csr_wdata;
            CSR_NORMAL_Y:     plane_in.normal_y     = csr_wdata;
            CSR_NORMAL_Z:     plane_in.normal_z     = csr_wdata;
            CSR_PLANE_OFFSET: plane_in.plane_offset = csr_wdata;
            default:          plane_in = plane_ff;
         endcase
      end
   end

   assign base_load = csr_we && (csr_index == CSR_VERTEX_BASE);

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff.normal_x     <= '0;
         plane_ff.normal_y     <= '0;
         plane_ff.normal_z     <= POS_W'(1 << FRAC_BITS);
         plane_ff.plane_offset <= '0;
      end else begin
         plane_ff <= plane_in;
      end
   end

   ctp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .plane     (plane_ff),
      .job_valid (job_valid_f),
      .job_ready (job_ready_f),
      .job_data  (job_data_f)
   );

   ctp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (job_valid_f),
      .in_ready  (job_ready_f),
      .in_data   (job_data_f),
      .out_valid (job_valid_b),
      .out_ready (job_ready_b),
      .out_data  (job_data_b)
   );

   ctp_back #(
      .INDEX_BITS (INDEX_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (job_valid_b),
      .job_ready  (job_ready_b),
      .job_data   (job_data_b),
      .base_load  (base_load),
      .base_value (csr_wdata[IDX_W-1:0]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

@@ design/ctp_checker.sv @@
`default_nettype none
`include "clip_triangles_by_plane_macros.svh"
module ctp_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire ctp_pkg::ctp_rsp_type rsp_data
);
   import ctp_pkg::*;

   // Results are gone in the cycle after reset
   `CTP_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")

   // A stalled result holds
   `CTP_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")

   // Triangle items carry no position
   `CTP_ASSERT(a_tri_no_pos, rsp_valid && rsp_data.kind == KIND_TRIANGLE |-> rsp_data.pos_x == '0 && rsp_data.pos_y == '0 && rsp_data.pos_z == '0, "triangle item with position")

   // Vertex items are never final and carry only their own index
   `CTP_ASSERT(a_vertex_shape, rsp_valid && rsp_data.kind == KIND_VERTEX |-> !rsp_data.last && rsp_data.out_index_b == '0 && rsp_data.out_index_c == '0, "malformed vertex item")

endmodule

bind clip_triangles_by_plane ctp_checker u_checker (.*);
`default_nettype wire
